// File: rtl/core/ptsd_pkg.sv
// ----------------------------------------------------------------------------
// ptsd_pkg
// Shared types, widths and codes for the point to segment distance unit.
// ----------------------------------------------------------------------------
package ptsd_pkg;

    // Coordinate width; the widths from DIFF_W to RT_W follow from it (range 8 to 16).
    localparam int COORD_BITS = 13;

    localparam int DIFF_W = COORD_BITS + 1;        // signed coordinate difference
    localparam int PW     = 2 * COORD_BITS + 2;    // signed product of two differences
    localparam int SQ_W   = 2 * COORD_BITS + 1;    // unsigned sum of two squares
    localparam int S_W    = PW + 1;                // signed line equation value
    localparam int N_W    = 3 * COORD_BITS + 4;    // signed foot numerator
    localparam int LO_W   = 3 * COORD_BITS + 1;    // x bound times squared length
    localparam int P_W    = 2 * COORD_BITS + 1;    // magnitude of line equation value
    localparam int PP_W   = 2 * P_W;               // its square
    localparam int NUM_W  = 4 * COORD_BITS + 4;    // dividend width
    localparam int QW     = 2 * COORD_BITS + 4;    // quotient width (even)
    localparam int ROOT_W = QW / 2;                // square root width
    localparam int RT_W   = ROOT_W + 3;            // square root remainder width

    localparam int          DIST_W   = 14;
    localparam int unsigned DIST_MAX = 16383;

    typedef enum logic [1:0] {
        KIND_COINCIDENT = 2'd0,
        KIND_OUTSIDE    = 2'd1,
        KIND_PERP       = 2'd2
    } kind_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] first_x;
        logic [COORD_BITS-1:0] first_y;
        logic [COORD_BITS-1:0] second_x;
        logic [COORD_BITS-1:0] second_y;
        logic [COORD_BITS-1:0] target_x;
        logic [COORD_BITS-1:0] target_y;
    } item_t;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic [1:0]        case_taken;
    } result_t;

    // Operands handed to the divide and square root pipeline.
    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [SQ_W-1:0]  dv;
        kind_t            kind;
    } root_in_t;

    typedef struct packed {
        logic [ROOT_W-1:0] root;
        kind_t             kind;
    } root_out_t;

endpackage

// File: rtl/core/ptsd_ratio_root.sv
// ----------------------------------------------------------------------------
// ptsd_ratio_root
// Pipelined floor(sqrt(floor(num / dv))): one quotient bit per stage of a
// restoring divider, then one root bit per stage of a restoring square root.
// ----------------------------------------------------------------------------
module ptsd_ratio_root (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  ptsd_pkg::root_in_t  in_data,
    output logic                out_valid,
    output ptsd_pkg::root_out_t out_data
);

    localparam int QW     = ptsd_pkg::QW;
    localparam int SQ_W   = ptsd_pkg::SQ_W;
    localparam int NUM_W  = ptsd_pkg::NUM_W;
    localparam int ROOT_W = ptsd_pkg::ROOT_W;
    localparam int RT_W   = ptsd_pkg::RT_W;

    typedef struct packed {
        logic [SQ_W-1:0]     rem;
        logic [QW-1:0]       work;
        logic [SQ_W-1:0]     dv;
        ptsd_pkg::kind_t     kind;
    } div_t;

    typedef struct packed {
        logic [RT_W-1:0]     rem;
        logic [ROOT_W-1:0]   root;
        logic [QW-1:0]       work;
        ptsd_pkg::kind_t     kind;
    } sq_t;

    div_t             div_reg [0:QW];
    div_t             div_next [1:QW];
    logic [QW:0]      div_valid_reg;
    sq_t              sq_cur [0:ROOT_W-1];
    sq_t              sq_reg [1:ROOT_W];
    sq_t              sq_next [1:ROOT_W];
    logic [ROOT_W:1]  sq_valid_reg;

    // The top bits of the dividend are known to be below the divisor, so they
    // seed the partial remainder directly.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            div_reg[0].rem  <= SQ_W'(in_data.num[NUM_W-1:QW]);
            div_reg[0].work <= in_data.num[QW-1:0];
            div_reg[0].dv   <= in_data.dv;
            div_reg[0].kind <= in_data.kind;
        end
    end

    for (genvar k = 0; k < QW; k++)
    begin : g_div
        logic [SQ_W:0] trial;
        logic          ge;

        always_comb
        begin
            trial = {div_reg[k].rem, div_reg[k].work[QW-1]};
            ge    = (trial >= {1'b0, div_reg[k].dv});
            div_next[k+1].rem  = ge ? SQ_W'(trial - {1'b0, div_reg[k].dv})
                                    : trial[SQ_W-1:0];
            div_next[k+1].work = {div_reg[k].work[QW-2:0], ge};
            div_next[k+1].dv   = div_reg[k].dv;
            div_next[k+1].kind = div_reg[k].kind;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                div_reg[k+1] <= div_next[k+1];
            end
        end
    end

    always_comb
    begin
        sq_cur[0].rem  = '0;
        sq_cur[0].root = '0;
        sq_cur[0].work = div_reg[QW].work;
        sq_cur[0].kind = div_reg[QW].kind;
    end

    for (genvar j = 1; j < ROOT_W; j++)
    begin : g_cur
        assign sq_cur[j] = sq_reg[j];
    end

    for (genvar j = 0; j < ROOT_W; j++)
    begin : g_sqrt
        logic [RT_W-1:0] rem_t;
        logic [RT_W-1:0] trial;
        logic            ge;

        always_comb
        begin
            rem_t = {sq_cur[j].rem[RT_W-3:0], sq_cur[j].work[QW-1:QW-2]};
            trial = RT_W'({sq_cur[j].root, 2'b01});
            ge    = (rem_t >= trial);
            sq_next[j+1].rem  = ge ? (rem_t - trial) : rem_t;
            sq_next[j+1].root = {sq_cur[j].root[ROOT_W-2:0], ge};
            sq_next[j+1].work = {sq_cur[j].work[QW-3:0], 2'b00};
            sq_next[j+1].kind = sq_cur[j].kind;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_reg[j+1] <= sq_next[j+1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_valid_reg <= '0;
            sq_valid_reg  <= '0;
        end
        else if (en)
        begin
            div_valid_reg <= {div_valid_reg[QW-1:0], in_valid};
            sq_valid_reg  <= {sq_valid_reg[ROOT_W-1:1], div_valid_reg[QW]};
        end
    end

    assign out_valid     = sq_valid_reg[ROOT_W];
    assign out_data.root = sq_reg[ROOT_W].root;
    assign out_data.kind = sq_reg[ROOT_W].kind;

endmodule

// File: rtl/core/point_to_segment_distance_unit.sv
// ----------------------------------------------------------------------------
// point_to_segment_distance_unit
// Distance from a target point to a segment, or to an endpoint, per item.
// ----------------------------------------------------------------------------
// The unit takes one item per clock while item_stall is low and returns one
// result per item, in order. An item passes through the six geometry stages,
// the restoring divider with its input register and one quotient bit per
// stage, the square root with one root bit per stage and the output register.
// The whole pipeline holds while a result waits under stall; item_stall is
// raised only then. Arithmetic is exact integer math.
module point_to_segment_distance_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  ptsd_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output ptsd_pkg::result_t result
);

    localparam int CB     = ptsd_pkg::COORD_BITS;
    localparam int DIFF_W = ptsd_pkg::DIFF_W;
    localparam int PW     = ptsd_pkg::PW;
    localparam int SQ_W   = ptsd_pkg::SQ_W;
    localparam int S_W    = ptsd_pkg::S_W;
    localparam int N_W    = ptsd_pkg::N_W;
    localparam int LO_W   = ptsd_pkg::LO_W;
    localparam int P_W    = ptsd_pkg::P_W;
    localparam int PP_W   = ptsd_pkg::PP_W;
    localparam int NUM_W  = ptsd_pkg::NUM_W;
    localparam int ROOT_W = ptsd_pkg::ROOT_W;
    localparam int DIST_W = ptsd_pkg::DIST_W;

    typedef struct packed {
        logic [CB-1:0]            x1, y1, x2, y2, tx, ty;
        logic [CB-1:0]            xlo, xhi;
        logic                     coin;
        logic signed [DIFF_W-1:0] a, b, e1x, e1y, e2x, e2y;
    } s1_t;

    typedef struct packed {
        logic [CB-1:0]            xlo, xhi;
        logic                     coin;
        logic signed [DIFF_W-1:0] a, b;
        logic signed [PW-1:0]     aa, bb, x2y1, x1y2, btx, aty, atx, bty;
        logic signed [PW-1:0]     e1xx, e1yy, e2xx, e2yy;
    } s2_t;

    typedef struct packed {
        logic [CB-1:0]            xlo, xhi;
        logic                     coin;
        logic signed [DIFF_W-1:0] a, b;
        logic [SQ_W-1:0]          d, dd1, dd2;
        logic signed [PW-1:0]     c, u, v;
    } s3_t;

    typedef struct packed {
        logic                     coin;
        logic [SQ_W-1:0]          d, dd1, dd2;
        logic signed [N_W-1:0]    bu, ac;
        logic signed [S_W-1:0]    s;
        logic [LO_W-1:0]          lo_d, hi_d;
    } s4_t;

    typedef struct packed {
        logic                     coin;
        logic [SQ_W-1:0]          d, dd1, dd2;
        logic signed [N_W-1:0]    n, lo_d, hi_d;
        logic [P_W-1:0]           p;
    } s5_t;

    typedef struct packed {
        logic                     coin;
        logic                     outside;
        logic [SQ_W-1:0]          d, dd1, dd2;
        logic [PP_W-1:0]          pp;
    } s6_t;

    logic                 en;
    s1_t                  s1_next, s1_reg;
    s2_t                  s2_next, s2_reg;
    s3_t                  s3_next, s3_reg;
    s4_t                  s4_next, s4_reg;
    s5_t                  s5_next, s5_reg;
    s6_t                  s6_next, s6_reg;
    logic [6:1]           valid_reg;
    logic [S_W-1:0]       s_abs;
    logic signed [PW-1:0] sum_d, sum_1, sum_2;
    ptsd_pkg::root_in_t   root_in;
    ptsd_pkg::root_out_t  root_out;
    logic                 root_valid;
    logic [ROOT_W:0]      root_inc;
    logic [ROOT_W-1:0]    dist_raw;
    ptsd_pkg::result_t    result_next, result_reg;
    logic                 result_valid_reg;

    // One enable for every stage: the pipeline only holds while a finished
    // result is waiting under stall.
    assign en         = !(result_valid_reg && result_stall);
    assign item_stall = !en;

    // Stage 1: differences and the x range of the segment.
    always_comb
    begin
        s1_next.x1   = item.first_x;
        s1_next.y1   = item.first_y;
        s1_next.x2   = item.second_x;
        s1_next.y2   = item.second_y;
        s1_next.tx   = item.target_x;
        s1_next.ty   = item.target_y;
        s1_next.xlo  = (item.first_x < item.second_x) ? item.first_x : item.second_x;
        s1_next.xhi  = (item.first_x < item.second_x) ? item.second_x : item.first_x;
        s1_next.coin = (item.first_x == item.second_x) && (item.first_y == item.second_y);
        s1_next.a    = $signed({1'b0, item.second_y}) - $signed({1'b0, item.first_y});
        s1_next.b    = $signed({1'b0, item.first_x}) - $signed({1'b0, item.second_x});
        s1_next.e1x  = $signed({1'b0, item.first_x}) - $signed({1'b0, item.target_x});
        s1_next.e1y  = $signed({1'b0, item.first_y}) - $signed({1'b0, item.target_y});
        s1_next.e2x  = $signed({1'b0, item.second_x}) - $signed({1'b0, item.target_x});
        s1_next.e2y  = $signed({1'b0, item.second_y}) - $signed({1'b0, item.target_y});
    end

    // Stage 2: all first-level products.
    always_comb
    begin
        s2_next.xlo  = s1_reg.xlo;
        s2_next.xhi  = s1_reg.xhi;
        s2_next.coin = s1_reg.coin;
        s2_next.a    = s1_reg.a;
        s2_next.b    = s1_reg.b;
        s2_next.aa   = PW'(s1_reg.a) * PW'(s1_reg.a);
        s2_next.bb   = PW'(s1_reg.b) * PW'(s1_reg.b);
        s2_next.x2y1 = PW'($signed({1'b0, s1_reg.x2})) * PW'($signed({1'b0, s1_reg.y1}));
        s2_next.x1y2 = PW'($signed({1'b0, s1_reg.x1})) * PW'($signed({1'b0, s1_reg.y2}));
        s2_next.btx  = PW'(s1_reg.b) * PW'($signed({1'b0, s1_reg.tx}));
        s2_next.aty  = PW'(s1_reg.a) * PW'($signed({1'b0, s1_reg.ty}));
        s2_next.atx  = PW'(s1_reg.a) * PW'($signed({1'b0, s1_reg.tx}));
        s2_next.bty  = PW'(s1_reg.b) * PW'($signed({1'b0, s1_reg.ty}));
        s2_next.e1xx = PW'(s1_reg.e1x) * PW'(s1_reg.e1x);
        s2_next.e1yy = PW'(s1_reg.e1y) * PW'(s1_reg.e1y);
        s2_next.e2xx = PW'(s1_reg.e2x) * PW'(s1_reg.e2x);
        s2_next.e2yy = PW'(s1_reg.e2y) * PW'(s1_reg.e2y);
    end

    // Stage 3: line coefficients, squared length and squared endpoint distances.
    always_comb
    begin
        sum_d = s2_reg.aa + s2_reg.bb;
        sum_1 = s2_reg.e1xx + s2_reg.e1yy;
        sum_2 = s2_reg.e2xx + s2_reg.e2yy;
        s3_next.xlo  = s2_reg.xlo;
        s3_next.xhi  = s2_reg.xhi;
        s3_next.coin = s2_reg.coin;
        s3_next.a    = s2_reg.a;
        s3_next.b    = s2_reg.b;
        s3_next.d    = sum_d[SQ_W-1:0];
        s3_next.dd1  = sum_1[SQ_W-1:0];
        s3_next.dd2  = sum_2[SQ_W-1:0];
        s3_next.c    = s2_reg.x2y1 - s2_reg.x1y2;
        s3_next.u    = s2_reg.btx - s2_reg.aty;
        s3_next.v    = s2_reg.atx + s2_reg.bty;
    end

    // Stage 4: the foot numerator is b*(b*tx - a*ty) - a*c.
    always_comb
    begin
        s4_next.coin = s3_reg.coin;
        s4_next.d    = s3_reg.d;
        s4_next.dd1  = s3_reg.dd1;
        s4_next.dd2  = s3_reg.dd2;
        s4_next.bu   = N_W'(s3_reg.b) * N_W'(s3_reg.u);
        s4_next.ac   = N_W'(s3_reg.a) * N_W'(s3_reg.c);
        s4_next.s    = S_W'(s3_reg.v) + S_W'(s3_reg.c);
        s4_next.lo_d = LO_W'(s3_reg.xlo) * LO_W'(s3_reg.d);
        s4_next.hi_d = LO_W'(s3_reg.xhi) * LO_W'(s3_reg.d);
    end

    // Stage 5: in the perpendicular case |s| is bounded by 2^(2*CB+1), so the
    // magnitude is narrowed to that.
    always_comb
    begin
        s_abs = s4_reg.s[S_W-1] ? S_W'(-s4_reg.s) : S_W'(s4_reg.s);
        s5_next.coin = s4_reg.coin;
        s5_next.d    = s4_reg.d;
        s5_next.dd1  = s4_reg.dd1;
        s5_next.dd2  = s4_reg.dd2;
        s5_next.n    = s4_reg.bu - s4_reg.ac;
        s5_next.lo_d = $signed(N_W'(s4_reg.lo_d));
        s5_next.hi_d = $signed(N_W'(s4_reg.hi_d));
        s5_next.p    = s_abs[P_W-1:0];
    end

    // Stage 6: exact range test of the foot and the square of |s|.
    always_comb
    begin
        s6_next.coin    = s5_reg.coin;
        s6_next.outside = (s5_reg.n < s5_reg.lo_d) || (s5_reg.n > s5_reg.hi_d);
        s6_next.d       = s5_reg.d;
        s6_next.dd1     = s5_reg.dd1;
        s6_next.dd2     = s5_reg.dd2;
        s6_next.pp      = PP_W'(s5_reg.p) * PP_W'(s5_reg.p);
    end

    // Endpoint cases divide by one; the perpendicular case takes the root of
    // 4*s^2/d and rounds it half up afterwards.
    always_comb
    begin
        if (s6_reg.coin)
        begin
            root_in.num  = NUM_W'(s6_reg.dd1);
            root_in.dv   = SQ_W'(1);
            root_in.kind = ptsd_pkg::KIND_COINCIDENT;
        end
        else if (s6_reg.outside)
        begin
            root_in.num  = NUM_W'(s6_reg.dd2);
            root_in.dv   = SQ_W'(1);
            root_in.kind = ptsd_pkg::KIND_OUTSIDE;
        end
        else
        begin
            root_in.num  = NUM_W'(s6_reg.pp) << 2;
            root_in.dv   = s6_reg.d;
            root_in.kind = ptsd_pkg::KIND_PERP;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
            s4_reg <= s4_next;
            s5_reg <= s5_next;
            s6_reg <= s6_next;
        end
    end

    ptsd_ratio_root u_ratio_root (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (valid_reg[6]),
        .in_data   (root_in),
        .out_valid (root_valid),
        .out_data  (root_out)
    );

    always_comb
    begin
        root_inc = {1'b0, root_out.root} + (ROOT_W + 1)'(1);
        if (root_out.kind == ptsd_pkg::KIND_PERP)
        begin
            dist_raw = root_inc[ROOT_W:1];
        end
        else
        begin
            dist_raw = root_out.root;
        end
        if (32'(dist_raw) > 32'(ptsd_pkg::DIST_MAX))
        begin
            result_next.distance = DIST_W'(ptsd_pkg::DIST_MAX);
        end
        else
        begin
            result_next.distance = DIST_W'(dist_raw);
        end
        result_next.case_taken = root_out.kind;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg        <= {valid_reg[5:1], item_valid};
            result_valid_reg <= root_valid;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// File: rtl/core/ptsd_checker.sv
// ----------------------------------------------------------------------------
// ptsd_checker
// Port-level checks for the point to segment distance unit.
// ----------------------------------------------------------------------------
module ptsd_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              item_valid,
    input logic              item_stall,
    input ptsd_pkg::item_t   item,
    input logic              result_valid,
    input logic              result_stall,
    input ptsd_pkg::result_t result
);

    // A waiting result is neither dropped nor changed.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result changed or dropped while stalled");

    // Input is held off only when a finished result is blocked.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid && result_stall)
        else $error("item stalled without a blocked result");

    // The output slot empties only through a delivered item.
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(result_valid) |-> $past(!result_stall))
        else $error("result vanished without delivery");

    // A result never rises out of a held pipeline.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(!item_stall))
        else $error("result appeared while the pipeline was held");

endmodule

bind point_to_segment_distance_unit ptsd_checker u_ptsd_checker (.*);
